// ===== src/utf8_to_utf16_transcoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 to UTF-16 transcoder
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transcoder check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transcoder check failed");

`endif

// ===== src/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and helpers shared by the transcoder modules.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Width of the internal byte counters; offsets saturate at all ones.
    localparam int OFFSET_BITS     = 16;
    // Width of the reported error offset.
    localparam int ERR_OFFSET_BITS = 16;
    localparam int SCALAR_BITS     = 21;
    localparam int UNIT_BITS       = 16;

    // Depth of the queue between the decoder and the output stage.
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ERR_OFFSET_BITS-1:0] ERR_OFFSET_MAX = '1;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_NO_CONT   = 3'd2,
        ERR_OVERLONG3 = 3'd3,
        ERR_SURROGATE = 3'd4,
        ERR_OVERLONG4 = 3'd5,
        ERR_ABOVE_MAX = 3'd6,
        ERR_BAD_LEAD  = 3'd7
    } err_kind_t;

    // One decoded event: a finished scalar or an error.
    typedef struct packed {
        logic [SCALAR_BITS-1:0]     scalar;
        err_kind_t                  kind;
        logic [ERR_OFFSET_BITS-1:0] err_offset;
        logic                       string_end;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [ERR_OFFSET_BITS-1:0] sat_offset(
        input logic [OFFSET_BITS-1:0] off
    );
        if (off > OFFSET_BITS'(ERR_OFFSET_MAX))
            return ERR_OFFSET_MAX;
        else
            return ERR_OFFSET_BITS'(off);
    endfunction

endpackage

// ===== src/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: tracks the open UTF-8 sequence and posts scalars or errors.
// ----------------------------------------------------------------------------
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output logic       push,
    output q_entry_t   push_entry
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic [1:0]             bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]             lead_byte_reg, lead_byte_next;
    logic [7:0]             second_byte_reg, second_byte_next;
    logic [SCALAR_BITS-1:0] partial_reg, partial_next;
    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic [OFFSET_BITS-1:0] seq_start_reg, seq_start_next;
    logic                   discarding_reg, discarding_next;

    function automatic logic [1:0] cont_needed(input logic [7:0] lead);
        if (lead >= 8'hF0)
            return 2'd3;
        else if (lead >= 8'hE0)
            return 2'd2;
        else
            return 2'd1;
    endfunction

    always_comb
    begin
        err_kind_t              kind;
        logic [OFFSET_BITS-1:0] eoff;
        logic                   have_scalar;
        logic [SCALAR_BITS-1:0] scalar;

        kind        = ERR_NONE;
        eoff        = '0;
        have_scalar = 1'b0;
        scalar      = '0;

        bytes_remaining_next = bytes_remaining_reg;
        lead_byte_next       = lead_byte_reg;
        second_byte_next     = second_byte_reg;
        partial_next         = partial_reg;
        position_next        = position_reg;
        seq_start_next       = seq_start_reg;
        discarding_next      = discarding_reg;
        push                 = 1'b0;
        push_entry           = '0;

        if (in_accept)
        begin
            position_next = (position_reg == POS_MAX) ? position_reg
                                                      : position_reg + 1'b1;
            if (discarding_reg)
            begin
                if (end_of_string)
                begin
                    bytes_remaining_next = '0;
                    lead_byte_next       = '0;
                    second_byte_next     = '0;
                    partial_next         = '0;
                    position_next        = '0;
                    seq_start_next       = '0;
                    discarding_next      = 1'b0;
                end
            end
            else
            begin
                if (bytes_remaining_reg == 2'd0)
                begin
                    seq_start_next   = position_reg;
                    lead_byte_next   = data_byte;
                    second_byte_next = '0;
                    if (data_byte inside {[8'h00:8'h7F]})
                    begin
                        have_scalar = 1'b1;
                        scalar      = SCALAR_BITS'(data_byte);
                    end
                    else if (data_byte inside {[8'hC2:8'hDF]})
                    begin
                        bytes_remaining_next = 2'd1;
                        partial_next         = SCALAR_BITS'(data_byte[4:0]);
                    end
                    else if (data_byte inside {[8'hE0:8'hEF]})
                    begin
                        bytes_remaining_next = 2'd2;
                        partial_next         = SCALAR_BITS'(data_byte[3:0]);
                    end
                    else if (data_byte inside {[8'hF0:8'hF4]})
                    begin
                        bytes_remaining_next = 2'd3;
                        partial_next         = SCALAR_BITS'(data_byte[2:0]);
                    end
                    else
                    begin
                        kind = ERR_BAD_LEAD;
                        eoff = position_reg;
                    end
                end
                else if (data_byte[7:6] != 2'b10)
                begin
                    kind = ERR_NO_CONT;
                    eoff = position_reg;
                end
                else
                begin
                    if (bytes_remaining_reg == cont_needed(lead_byte_reg))
                        second_byte_next = data_byte;
                    partial_next = {partial_reg[SCALAR_BITS-7:0], data_byte[5:0]};
                    bytes_remaining_next = bytes_remaining_reg - 2'd1;
                    if (bytes_remaining_next == 2'd0)
                    begin
                        // Range checks only once the whole sequence is in.
                        if (lead_byte_reg == 8'hE0 && second_byte_next < 8'hA0)
                            kind = ERR_OVERLONG3;
                        else if (lead_byte_reg == 8'hED && second_byte_next >= 8'hA0)
                            kind = ERR_SURROGATE;
                        else if (lead_byte_reg == 8'hF0 && second_byte_next < 8'h90)
                            kind = ERR_OVERLONG4;
                        else if (lead_byte_reg == 8'hF4 && second_byte_next > 8'h8F)
                            kind = ERR_ABOVE_MAX;
                        if (kind != ERR_NONE)
                            eoff = seq_start_reg;
                        else
                        begin
                            have_scalar = 1'b1;
                            scalar      = partial_next;
                        end
                    end
                end

                if (kind == ERR_NONE && bytes_remaining_next != 2'd0 && end_of_string)
                begin
                    kind = ERR_TRUNCATED;
                    eoff = seq_start_next;
                end

                if (kind != ERR_NONE || have_scalar)
                begin
                    push                  = 1'b1;
                    push_entry.scalar     = (kind == ERR_NONE) ? scalar : '0;
                    push_entry.kind       = kind;
                    push_entry.err_offset = sat_offset(eoff);
                    push_entry.string_end = end_of_string;
                    if (have_scalar && kind == ERR_NONE)
                        partial_next = '0;
                    if (end_of_string)
                    begin
                        bytes_remaining_next = '0;
                        lead_byte_next       = '0;
                        second_byte_next     = '0;
                        partial_next         = '0;
                        position_next        = '0;
                        seq_start_next       = '0;
                        discarding_next      = 1'b0;
                    end
                    else if (kind != ERR_NONE)
                    begin
                        bytes_remaining_next = '0;
                        discarding_next      = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_remaining_reg <= '0;
            lead_byte_reg       <= '0;
            second_byte_reg     <= '0;
            partial_reg         <= '0;
            position_reg        <= '0;
            seq_start_reg       <= '0;
            discarding_reg      <= 1'b0;
        end
        else
        begin
            bytes_remaining_reg <= bytes_remaining_next;
            lead_byte_reg       <= lead_byte_next;
            second_byte_reg     <= second_byte_next;
            partial_reg         <= partial_next;
            position_reg        <= position_next;
            seq_start_reg       <= seq_start_next;
            discarding_reg      <= discarding_next;
        end
    end

endmodule

// ===== src/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// Short first-in first-out queue of decoded events.
// ----------------------------------------------------------------------------
module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head_entry,
    output q_status_t status
);

    q_entry_t                  entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_entry   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back
// Output stage: turns queued events into UTF-16 beats, splitting pairs.
// ----------------------------------------------------------------------------
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  q_entry_t                   head_entry,
    input  q_status_t                  status,
    output logic                       pop,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [UNIT_BITS-1:0]       code_unit,
    output err_kind_t                  error_kind,
    output logic [ERR_OFFSET_BITS-1:0] error_offset,
    output logic                       run_last,
    output logic                       string_done
);

    logic                       valid_reg, valid_next;
    logic                       pair_low_reg, pair_low_next;
    logic [UNIT_BITS-1:0]       unit_reg, unit_next;
    err_kind_t                  kind_reg, kind_next;
    logic [ERR_OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                       last_reg, last_next;
    logic                       done_reg, done_next;
    logic                       load;
    logic [SCALAR_BITS-1:0]     supp;

    assign load = !valid_reg || out_ready;
    assign supp = head_entry.scalar - SCALAR_BITS'(21'h10000);

    always_comb
    begin
        valid_next    = valid_reg;
        pair_low_next = pair_low_reg;
        unit_next     = unit_reg;
        kind_next     = kind_reg;
        offset_next   = offset_reg;
        last_next     = last_reg;
        done_next     = done_reg;
        pop           = 1'b0;
        if (load)
        begin
            valid_next = !status.empty;
            if (!status.empty)
            begin
                kind_next   = head_entry.kind;
                offset_next = head_entry.err_offset;
                if (pair_low_reg)
                begin
                    // Low surrogate: 0xDC00 plus the bottom ten bits.
                    unit_next     = {6'b110111, supp[9:0]};
                    last_next     = 1'b1;
                    done_next     = head_entry.string_end;
                    pair_low_next = 1'b0;
                    pop           = 1'b1;
                end
                else if (head_entry.kind != ERR_NONE)
                begin
                    unit_next = '0;
                    last_next = 1'b1;
                    done_next = 1'b1;
                    pop       = 1'b1;
                end
                else if (head_entry.scalar[SCALAR_BITS-1:UNIT_BITS] != '0)
                begin
                    // High surrogate first; the entry stays for its partner.
                    unit_next     = {6'b110110, supp[19:10]};
                    last_next     = 1'b0;
                    done_next     = 1'b0;
                    pair_low_next = 1'b1;
                end
                else
                begin
                    unit_next = head_entry.scalar[UNIT_BITS-1:0];
                    last_next = 1'b1;
                    done_next = head_entry.string_end;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            pair_low_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            pair_low_reg <= pair_low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg   <= unit_next;
        kind_reg   <= kind_next;
        offset_reg <= offset_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    assign out_valid    = valid_reg;
    assign code_unit    = unit_reg;
    assign error_kind   = kind_reg;
    assign error_offset = offset_reg;
    assign run_last     = last_reg;
    assign string_done  = done_reg;

endmodule

// ===== src/utf8_to_utf16_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Strict UTF-8 to UTF-16 transcoder with a decoupled decoder and output stage.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents
// s_*       in   tdata[7:0] data byte, tlast end of string
// m_*       out  tdata code unit and error offset, tlast last beat of the byte,
//                tuser error kind and end-of-string flag
//
// The block takes one byte per cycle whenever the event queue has room.
// A decoded event is queued, then loaded into the output register; a
// four-byte scalar yields two beats (high then low surrogate) from one
// queue entry, so the output stage, not the decoder, sets the beat rate.
// A stalled m_tready fills the four-entry queue, after which s_tready drops.
// Reset clears the sequence state, byte counters, queue and output valid.
//
module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] code_unit, [31:16] error_offset
    output logic        m_tlast,   // run_last
    output logic [3:0]  m_tuser    // [2:0] error_kind, [3] string_done
);

    logic      in_accept;
    logic      push;
    q_entry_t  push_entry;
    logic      pop;
    q_entry_t  head_entry;
    q_status_t q_status;
    err_kind_t error_kind;
    logic [UNIT_BITS-1:0]       code_unit;
    logic [ERR_OFFSET_BITS-1:0] error_offset;
    logic                       string_done;

    // The decoder never stalls on its own; only a full queue holds off input.
    assign s_tready  = !q_status.full;
    assign in_accept = s_tvalid && s_tready;

    u8u16_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_accept),
        .data_byte     (s_tdata),
        .end_of_string (s_tlast),
        .push          (push),
        .push_entry    (push_entry)
    );

    u8u16_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    u8u16_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_entry   (head_entry),
        .status       (q_status),
        .pop          (pop),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .code_unit    (code_unit),
        .error_kind   (error_kind),
        .error_offset (error_offset),
        .run_last     (m_tlast),
        .string_done  (string_done)
    );

    assign m_tdata = {error_offset, code_unit};
    assign m_tuser = {string_done, error_kind};

endmodule

// ===== src/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder's output beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_core_assert.svh"

module u8u16_checker
    import u8u16_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [3:0]  m_tuser
);

    logic ok_beat;
    logic err_beat;

    assign ok_beat  = m_tvalid && (m_tuser[2:0] == ERR_NONE);
    assign err_beat = m_tvalid && (m_tuser[2:0] != ERR_NONE);

    // A stalled beat stays offered and unchanged.
    `U8U16_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // Good beats carry no error offset.
    `U8U16_ASSERT_IMPLY(a_ok_offset, clk, rst_n, ok_beat, m_tdata[31:16] == 16'h0000)

    // An error beat is empty and closes both the byte and the string.
    `U8U16_ASSERT_IMPLY(a_err_shape, clk, rst_n, err_beat, m_tdata[15:0] == 16'h0000 && m_tlast && m_tuser[3])

    // The end of a string is always the last beat of its byte.
    `U8U16_ASSERT_IMPLY(a_done_last, clk, rst_n, m_tvalid && m_tuser[3], m_tlast)

    // The only beat that is not last for its byte is a high surrogate.
    `U8U16_ASSERT_IMPLY(a_high_sur, clk, rst_n, m_tvalid && !m_tlast, m_tdata[15:10] == 6'b110110)

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: UTF-8 to UTF-16 transcoder testbench
// Drives byte strings into the transcoder and compares every output beat
// with a behavioural model of strict UTF-8 decoding or a typed beat. A
// short table of directed strings comes first, then random strings under
// several idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import u8u16_pkg::*;

    // One output beat as the block presents it.
    typedef struct packed {
        logic [15:0] unit;
        err_kind_t   kind;
        logic [15:0] offset;
        logic        last;
        logic        done;
    } utf16_beat_t;

    // A directed row: one input byte, and where it is obvious, its beat.
    typedef struct packed {
        logic [7:0]  data;
        logic        eos;
        logic        typed;
        logic [15:0] unit;
        err_kind_t   kind;
        logic [15:0] offset;
        logic        done;
    } byte_row_t;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 450;
    localparam int GAP_PCT[4]   = '{0, 73, 0, 19};
    localparam int STALL_PCT[4] = '{0, 0, 73, 19};

    // Directed strings. Typed rows carry their beat; the rest use the model.
    localparam byte_row_t DIRECTED[0:27] = '{
        '{8'h00, 1'b0, 1'b1, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h7F, 1'b1, 1'b1, 16'h007F, ERR_NONE,      16'h0000, 1'b1},
        // Highest scalar, U+10FFFF, as a surrogate pair.
        '{8'hF4, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'hBF, 1'b1, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        // Overlong three-byte form before the end, then a dropped final byte.
        '{8'hE0, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h9F, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b1, 16'h0000, ERR_OVERLONG3, 16'h0000, 1'b1},
        '{8'hFF, 1'b1, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        // Encoded surrogate, error on the final byte.
        '{8'hED, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'hA0, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h80, 1'b1, 1'b1, 16'h0000, ERR_SURROGATE, 16'h0000, 1'b1},
        // Overlong four-byte form.
        '{8'hF0, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'hBF, 1'b1, 1'b1, 16'h0000, ERR_OVERLONG4, 16'h0000, 1'b1},
        // Above U+10FFFF, reported at the lead byte after one good scalar.
        '{8'h41, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'hF4, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h90, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b1, 16'h0000, ERR_ABOVE_MAX, 16'h0001, 1'b1},
        '{8'hC3, 1'b1, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        // Missing continuation, reported at the offending byte.
        '{8'hC3, 1'b0, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        '{8'h41, 1'b0, 1'b1, 16'h0000, ERR_NO_CONT,   16'h0001, 1'b1},
        '{8'h80, 1'b1, 1'b0, 16'h0000, ERR_NONE,      16'h0000, 1'b0},
        // Bad lead byte, then a string cut short after its lead byte.
        '{8'hF8, 1'b1, 1'b1, 16'h0000, ERR_BAD_LEAD,  16'h0000, 1'b1},
        '{8'hE2, 1'b1, 1'b1, 16'h0000, ERR_TRUNCATED, 16'h0000, 1'b1}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    // Decoder model state.
    logic [1:0]  seq_left;
    logic [7:0]  seq_lead;
    logic [7:0]  seq_second;
    logic [20:0] seq_bits;
    logic [15:0] str_pos;
    logic [15:0] seq_start;
    logic        dropping;

    utf16_beat_t step_beats[2];
    utf16_beat_t awaited_beats[$];
    logic [7:0]  str_bytes[$];

    int gap_pct;
    int stall_pct;
    int live_items;
    int fail_count;
    int quiet_cycles;

    utf8_to_utf16_transcoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic clear_string();
        seq_left   = '0;
        seq_lead   = '0;
        seq_second = '0;
        seq_bits   = '0;
        str_pos    = '0;
        seq_start  = '0;
        dropping   = 1'b0;
    endtask

    // Decodes one byte, updates the model state and leaves its beats in
    // step_beats; n is how many beats the byte causes.
    task automatic transcode_byte(input logic [7:0] b, input logic eos, output int n);
        logic [15:0] pos;
        err_kind_t   kind;
        logic [15:0] eoff;
        logic        scalar_ready;
        logic [20:0] scalar;
        logic [20:0] v;
        logic [1:0]  needed;
        pos          = str_pos;
        kind         = ERR_NONE;
        eoff         = '0;
        scalar_ready = 1'b0;
        scalar       = '0;
        n            = 0;
        if (str_pos != 16'hFFFF)
            str_pos = str_pos + 16'd1;

        if (dropping)
        begin
            if (eos)
                clear_string();
        end
        else
        begin
            if (seq_left == 2'd0)
            begin
                seq_start  = pos;
                seq_lead   = b;
                seq_second = '0;
                if (b <= 8'h7F)
                begin
                    scalar_ready = 1'b1;
                    scalar       = {13'd0, b};
                end
                else if (b >= 8'hC2 && b <= 8'hDF)
                begin
                    seq_left = 2'd1;
                    seq_bits = {16'd0, b[4:0]};
                end
                else if (b >= 8'hE0 && b <= 8'hEF)
                begin
                    seq_left = 2'd2;
                    seq_bits = {17'd0, b[3:0]};
                end
                else if (b >= 8'hF0 && b <= 8'hF4)
                begin
                    seq_left = 2'd3;
                    seq_bits = {18'd0, b[2:0]};
                end
                else
                begin
                    kind = ERR_BAD_LEAD;
                    eoff = pos;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                kind = ERR_NO_CONT;
                eoff = pos;
            end
            else
            begin
                needed = (seq_lead >= 8'hF0) ? 2'd3 : (seq_lead >= 8'hE0) ? 2'd2 : 2'd1;
                if (seq_left == needed)
                    seq_second = b;
                seq_bits = {seq_bits[14:0], b[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0)
                begin
                    // Range checks only once the sequence is complete.
                    if (seq_lead == 8'hE0 && seq_second < 8'hA0)
                        kind = ERR_OVERLONG3;
                    else if (seq_lead == 8'hED && seq_second >= 8'hA0)
                        kind = ERR_SURROGATE;
                    else if (seq_lead == 8'hF0 && seq_second < 8'h90)
                        kind = ERR_OVERLONG4;
                    else if (seq_lead == 8'hF4 && seq_second > 8'h8F)
                        kind = ERR_ABOVE_MAX;
                    if (kind != ERR_NONE)
                        eoff = seq_start;
                    else
                    begin
                        scalar_ready = 1'b1;
                        scalar       = seq_bits;
                    end
                end
            end

            if (kind == ERR_NONE && seq_left != 2'd0 && eos)
            begin
                kind = ERR_TRUNCATED;
                eoff = seq_start;
            end

            if (kind != ERR_NONE)
            begin
                step_beats[0] = '{16'h0000, kind, eoff, 1'b1, 1'b1};
                n = 1;
                if (eos)
                    clear_string();
                else
                begin
                    seq_left = '0;
                    dropping = 1'b1;
                end
            end
            else if (scalar_ready)
            begin
                if (scalar <= 21'h00FFFF)
                begin
                    step_beats[0] = '{scalar[15:0], ERR_NONE, 16'h0000, 1'b1, eos};
                    n = 1;
                end
                else
                begin
                    v = scalar - 21'h010000;
                    step_beats[0] = '{16'hD800 + {6'd0, v[19:10]}, ERR_NONE, 16'h0000,
                                      1'b0, 1'b0};
                    step_beats[1] = '{16'hDC00 + {6'd0, v[9:0]}, ERR_NONE, 16'h0000,
                                      1'b1, eos};
                    n = 2;
                end
                seq_bits = '0;
                if (eos)
                    clear_string();
            end
        end
    endtask

    // Queues a beat at the tail of the list of awaited beats.
    task automatic await_beat(input utf16_beat_t beat);
        awaited_beats.insert(awaited_beats.size(), beat);
    endtask

    // Presents one byte, waits for the handshake and records what it should
    // produce. A typed beat replaces the model's single beat for that byte.
    task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input utf16_beat_t typed_beat);
        int n;
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (!dropping)
            live_items++;
        transcode_byte(b, eos, n);
        if (typed)
            await_beat(typed_beat);
        else
            for (int i = 0; i < n; i++)
                await_beat(step_beats[i]);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    // Appends one byte to the string being built.
    task automatic add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    // Appends the UTF-8 encoding of a scalar value.
    task automatic push_scalar(input int unsigned cp);
        if (cp < 'h80)
            add_byte(8'(cp));
        else if (cp < 'h800)
        begin
            add_byte(8'hC0 | 8'(cp >> 6));
            add_byte(8'h80 | 8'(cp & 'h3F));
        end
        else if (cp < 'h10000)
        begin
            add_byte(8'hE0 | 8'(cp >> 12));
            add_byte(8'h80 | 8'((cp >> 6) & 'h3F));
            add_byte(8'h80 | 8'(cp & 'h3F));
        end
        else
        begin
            add_byte(8'hF0 | 8'(cp >> 18));
            add_byte(8'h80 | 8'((cp >> 12) & 'h3F));
            add_byte(8'h80 | 8'((cp >> 6) & 'h3F));
            add_byte(8'h80 | 8'(cp & 'h3F));
        end
    endtask

    // Appends a well-formed scalar, biased towards the class boundaries.
    task automatic push_good_scalar();
        int unsigned edges[10] = '{'h0, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000,
                                   'hFFFF, 'h10000, 'h10FFFF};
        int unsigned cp;
        if ($urandom_range(99) < 20)
            cp = edges[$urandom_range(9)];
        else
            case ($urandom_range(3))
                0: cp = $urandom_range('h7F);
                1: cp = $urandom_range('h7FF, 'h80);
                2: cp = $urandom_range('hFFFF, 'h800);
                default: cp = $urandom_range('h10FFFF, 'h10000);
            endcase
        // Keep clear of the surrogate block.
        if (cp >= 'hD800 && cp <= 'hDFFF)
            cp = cp ^ 'h2000;
        push_scalar(cp);
    endtask

    // Appends one malformed sequence of a random kind.
    task automatic push_bad_sequence();
        logic [7:0] lead;
        case ($urandom_range(7))
            0:
            begin
                add_byte(8'hC0 | 8'($urandom_range(1)));
                add_byte(cont_byte());
            end
            1:
            begin
                add_byte(8'hE0);
                add_byte(8'($urandom_range('h9F, 'h80)));
                add_byte(cont_byte());
            end
            2:
            begin
                add_byte(8'hED);
                add_byte(8'($urandom_range('hBF, 'hA0)));
                add_byte(cont_byte());
            end
            3:
            begin
                add_byte(8'hF0);
                add_byte(8'($urandom_range('h8F, 'h80)));
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
            4:
            begin
                add_byte(8'hF4);
                add_byte(8'($urandom_range('hBF, 'h90)));
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
            5: add_byte(8'($urandom_range('hFF, 'hF5)));
            6: add_byte(cont_byte());
            default:
            begin
                lead = 8'($urandom_range('hF4, 'hC2));
                add_byte(lead);
                if ($urandom_range(1))
                    add_byte(8'($urandom_range('h7F)));
                else
                    add_byte(8'($urandom_range('hFF, 'hC0)));
            end
        endcase
    endtask

    // Builds one random string: mostly valid text, sometimes with a bad
    // sequence, a corrupted byte or a cut-off tail, and now and then noise.
    task automatic build_string();
        int         count;
        logic [7:0] lead;
        int         needed;
        str_bytes.delete();
        if ($urandom_range(99) < 8)
        begin
            count = $urandom_range(6, 1);
            for (int i = 0; i < count; i++)
                add_byte(8'($urandom));
        end
        else
        begin
            count = $urandom_range(8, 1);
            for (int i = 0; i < count; i++)
                if ($urandom_range(99) < 8)
                    push_bad_sequence();
                else
                    push_good_scalar();
            if ($urandom_range(99) < 6)
                str_bytes[$urandom_range(str_bytes.size() - 1)] = 8'($urandom);
            if ($urandom_range(99) < 6)
            begin
                lead   = 8'($urandom_range('hF4, 'hC2));
                needed = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
                add_byte(lead);
                for (int i = $urandom_range(needed - 1); i > 0; i--)
                    add_byte(cont_byte());
            end
        end
    endtask

    // The receiver stalls at random; the rate follows the current phase.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Output checker and watchdog. Every accepted beat is matched against the
    // oldest awaited one; a long stretch with no beat on either side ends the run.
    always @(posedge clk)
    begin
        utf16_beat_t exp_beat;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (m_tvalid && m_tready)
            begin
                if (awaited_beats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected beat: unit %h kind %0d offset %h last %b done %b",
                                 m_tdata[15:0], m_tuser[2:0], m_tdata[31:16], m_tlast,
                                 m_tuser[3]);
                end
                else
                begin
                    exp_beat = awaited_beats.pop_front();
                    if (m_tdata[15:0] !== exp_beat.unit || m_tuser[2:0] !== exp_beat.kind
                        || m_tdata[31:16] !== exp_beat.offset || m_tlast !== exp_beat.last
                        || m_tuser[3] !== exp_beat.done)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"beat mismatch: unit %h/%h kind %0d/%0d offset %h/%h",
                                      " last %b/%b done %b/%b (expected/actual)"},
                                     exp_beat.unit, m_tdata[15:0], exp_beat.kind,
                                     m_tuser[2:0], exp_beat.offset, m_tdata[31:16],
                                     exp_beat.last, m_tlast, exp_beat.done, m_tuser[3]);
                    end
                end
            end

            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int target;
        utf16_beat_t typed_beat;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        m_tready     <= 1'b0;
        gap_pct      = 0;
        stall_pct    = 0;
        live_items   = 0;
        fail_count   = 0;
        quiet_cycles = 0;
        clear_string();

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings, no idling.
        foreach (DIRECTED[i])
        begin
            typed_beat = '{DIRECTED[i].unit, DIRECTED[i].kind, DIRECTED[i].offset, 1'b1,
                           DIRECTED[i].done};
            send_byte(DIRECTED[i].data, DIRECTED[i].eos, DIRECTED[i].typed, typed_beat);
        end

        // Random strings, one idling pattern per phase.
        for (int phase = 0; phase < 4; phase++)
        begin
            gap_pct   = GAP_PCT[phase];
            stall_pct = STALL_PCT[phase];
            target    = live_items + PHASE_ITEMS;
            while (live_items < target)
            begin
                build_string();
                foreach (str_bytes[i])
                    send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b0, typed_beat);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then keep watching for any stray beat to show up.
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);

        if (fail_count == 0 && awaited_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== utf8_to_utf16_transcoder_core.f =====
+incdir+src
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_queue.sv
src/u8u16_back.sv
src/utf8_to_utf16_transcoder_core.sv
src/u8u16_checker.sv
tb/tb_top.sv
